// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its condition.
`define ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Property that must hold in the cycle after its condition.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/sros_pkg.sv -----
// Types and constants shared by the sector range order scheduler.
`timescale 1ns / 1ps

package sros_pkg;

    localparam int SLOT_FIELD_W = 4;
    localparam int COUNT_W      = 7;
    localparam int KIND_W       = 3;
    localparam int OUT_TDATA_W  = 8;

    localparam logic CMD_SUBMIT   = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUEUED       = 3'd0,
        KIND_DISPATCHED   = 3'd1,
        KIND_RETIRED      = 3'd2,
        KIND_TABLE_FULL   = 3'd3,
        KIND_TOO_LONG     = 3'd4,
        KIND_BAD_COMPLETE = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SETTLE,
        S_WAKE,
        S_FINAL
    } t_state;

endpackage

// ----- rtl/sros_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module sros_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sros_overlap.sv -----
// Shared sector range overlap comparator with wraparound.
`timescale 1ns / 1ps

module sros_overlap #(
    parameter int SECTOR_BITS = 48,
    parameter int TAG_W       = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [TAG_W-1:0]             i_tag,
    input  logic [SECTOR_BITS-1:0]       i_a_start,
    input  logic [sros_pkg::COUNT_W-1:0] i_a_count,
    input  logic [SECTOR_BITS-1:0]       i_b_start,
    input  logic [sros_pkg::COUNT_W-1:0] i_b_count,
    output logic                         o_valid,
    output logic [TAG_W-1:0]             o_tag,
    output logic                         o_hit
);

    logic                         r_valid;
    logic [TAG_W-1:0]             r_tag;
    logic [SECTOR_BITS-1:0]       r_d_ba;
    logic [SECTOR_BITS-1:0]       r_d_ab;
    logic [sros_pkg::COUNT_W-1:0] r_ca;
    logic [sros_pkg::COUNT_W-1:0] r_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= i_tag;
        r_d_ba <= i_b_start - i_a_start;
        r_d_ab <= i_a_start - i_b_start;
        r_ca   <= i_a_count;
        r_cb   <= i_b_count;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_hit   = (r_ca != '0) && (r_cb != '0) &&
                     ((r_d_ba < SECTOR_BITS'(r_ca)) || (r_d_ab < SECTOR_BITS'(r_cb)));

endmodule

// ----- rtl/sector_range_order_scheduler_top.sv -----
// Top level of the sector range order scheduler: slot tables and sequencer.
//
// Channel  | Direction | tdata (low bit up)                       | tuser   | tlast
// s_axis   | in        | slot, start_sector, sector_count, zeros  | command | -
// m_axis   | out       | result_slot, zeros                       | kind    | last
//
// A submit compares its range with every slot entry through the shared comparator,
// fed one entry a cycle from the range memory; only hits on slots stored before it count.
// A complete walks the age ranks in order to wake slots that are no longer blocked.
// Every item also waits while a result finds the output register full.
// Rejected items skip the scan and the walk. Input is taken only while the sequencer idles.
// Reset is synchronous and clears the slot flags at once; there is no clearing pass.
`timescale 1ns / 1ps

module sector_range_order_scheduler_top #(
    parameter int SLOTS       = 16,
    parameter int MAX_LENGTH  = 64,
    parameter int SECTOR_BITS = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // slot, start_sector, sector_count, zero fill
    input  logic [((sros_pkg::SLOT_FIELD_W + SECTOR_BITS + sros_pkg::COUNT_W + 7) / 8) * 8 - 1:0]
                 i_s_axis_tdata,
    // command
    input  logic i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // result_slot, zero fill
    output logic [sros_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // kind
    output logic [sros_pkg::KIND_W-1:0]      o_m_axis_tuser,
    output logic o_m_axis_tlast
);

    localparam int SW  = $clog2(SLOTS);
    localparam int IW  = (SW > sros_pkg::SLOT_FIELD_W) ? SW : sros_pkg::SLOT_FIELD_W;
    localparam int CW  = sros_pkg::COUNT_W;
    localparam int FW  = sros_pkg::SLOT_FIELD_W;
    localparam int RAMW = SECTOR_BITS + CW;

    function automatic logic [FW-1:0] to_field(input logic [SW-1:0] v);
        logic [IW-1:0] w;
        w = IW'(v);
        return w[FW-1:0];
    endfunction

    sros_pkg::t_state r_state, n_state;

    logic                   r_cmd;
    logic [FW-1:0]          r_in_slot;
    logic [SECTOR_BITS-1:0] r_in_start;
    logic [CW-1:0]          r_in_count;

    logic [SLOTS-1:0] r_valid, n_valid;
    logic [SLOTS-1:0] r_disp, n_disp;
    logic [SLOTS-1:0] r_block [SLOTS];
    logic [SLOTS-1:0] n_block [SLOTS];
    logic [SW-1:0]    r_rank [SLOTS];
    logic [SW-1:0]    n_rank [SLOTS];
    logic [SW:0]      r_nvalid, n_nvalid;
    logic [SLOTS-1:0] r_mask, n_mask;
    logic [SW-1:0]    r_cur, n_cur;
    logic [SW:0]      r_cnt, n_cnt;

    sros_pkg::t_kind  r_fin_kind, n_fin_kind;
    logic [FW-1:0]    r_fin_slot, n_fin_slot;

    logic             r_rd_valid;
    logic [SW-1:0]    r_rd_tag;

    logic             r_o_valid, n_o_valid;
    sros_pkg::t_kind  r_o_kind, n_o_kind;
    logic [FW-1:0]    r_o_slot, n_o_slot;
    logic             r_o_last, n_o_last;

    logic             in_accept;
    logic             out_free;
    logic             issue;
    logic             ram_we;
    logic [SW-1:0]    ram_waddr;
    logic [RAMW-1:0]  ram_wdata;
    logic [RAMW-1:0]  ram_rdata;
    logic             ov_valid;
    logic [SW-1:0]    ov_tag;
    logic             ov_hit;

    logic [SW-1:0]    free_idx;
    logic             free_any;
    logic [SLOTS-1:0] match;
    logic [SW-1:0]    match_idx;
    logic [SW-1:0]    s_idx;
    logic             bad_complete;
    logic             too_long;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == sros_pkg::S_IDLE);
    assign issue           = (r_state == sros_pkg::S_SCAN) && (r_cnt < (SW + 1)'(SLOTS));

    sros_ram #(
        .WIDTH (RAMW),
        .DEPTH (SLOTS)
    ) u_range_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[SW-1:0]),
        .o_rdata (ram_rdata)
    );

    sros_overlap #(
        .SECTOR_BITS (SECTOR_BITS),
        .TAG_W       (SW)
    ) u_overlap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_rd_valid),
        .i_tag     (r_rd_tag),
        .i_a_start (r_in_start),
        .i_a_count (r_in_count),
        .i_b_start (ram_rdata[SECTOR_BITS-1:0]),
        .i_b_count (ram_rdata[SECTOR_BITS +: CW]),
        .o_valid   (ov_valid),
        .o_tag     (ov_tag),
        .o_hit     (ov_hit)
    );

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
        match_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = r_valid[i] && !r_disp[i] && !(|r_block[i]) &&
                       (r_rank[i] == r_cnt[SW-1:0]);
            if (match[i]) begin
                match_idx = match_idx | SW'(i);
            end
        end
    end

    assign s_idx        = SW'(r_in_slot);
    assign too_long     = int'(r_in_count) > MAX_LENGTH;
    assign bad_complete = (int'(r_in_slot) >= SLOTS) || !r_valid[s_idx] || !r_disp[s_idx];

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_disp     = r_disp;
        n_block    = r_block;
        n_rank     = r_rank;
        n_nvalid   = r_nvalid;
        n_mask     = r_mask;
        n_cur      = r_cur;
        n_cnt      = r_cnt;
        n_fin_kind = r_fin_kind;
        n_fin_slot = r_fin_slot;
        n_o_valid  = r_o_valid && !i_m_axis_tready;
        n_o_kind   = r_o_kind;
        n_o_slot   = r_o_slot;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = free_idx;
        ram_wdata  = {r_in_count, r_in_start};

        if (ov_valid && ov_hit && r_mask[ov_tag]) begin
            n_block[r_cur][ov_tag] = 1'b1;
        end

        unique case (r_state)
            sros_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = sros_pkg::S_DECODE;
                end
            end
            sros_pkg::S_DECODE: begin
                n_cnt = '0;
                if (r_cmd == sros_pkg::CMD_SUBMIT) begin
                    if (too_long) begin
                        n_fin_kind = sros_pkg::KIND_TOO_LONG;
                        n_fin_slot = '0;
                        n_state    = sros_pkg::S_FINAL;
                    end else if (!free_any) begin
                        n_fin_kind = sros_pkg::KIND_TABLE_FULL;
                        n_fin_slot = '0;
                        n_state    = sros_pkg::S_FINAL;
                    end else begin
                        ram_we            = 1'b1;
                        n_valid[free_idx] = 1'b1;
                        n_disp[free_idx]  = 1'b0;
                        n_block[free_idx] = '0;
                        n_rank[free_idx]  = r_nvalid[SW-1:0];
                        n_nvalid          = r_nvalid + 1'b1;
                        n_mask            = r_valid;
                        n_cur             = free_idx;
                        n_state           = sros_pkg::S_SCAN;
                    end
                end else if (bad_complete) begin
                    n_fin_kind = sros_pkg::KIND_BAD_COMPLETE;
                    n_fin_slot = r_in_slot;
                    n_state    = sros_pkg::S_FINAL;
                end else begin
                    n_valid[s_idx] = 1'b0;
                    n_disp[s_idx]  = 1'b0;
                    n_block[s_idx] = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        n_block[i][s_idx] = 1'b0;
                        if (r_valid[i] && (r_rank[i] > r_rank[s_idx])) begin
                            n_rank[i] = r_rank[i] - 1'b1;
                        end
                    end
                    n_nvalid   = r_nvalid - 1'b1;
                    n_cur      = s_idx;
                    n_fin_kind = sros_pkg::KIND_RETIRED;
                    n_fin_slot = r_in_slot;
                    n_state    = sros_pkg::S_WAKE;
                end
            end
            sros_pkg::S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (SW + 1)'(SLOTS + 1)) begin
                    n_state = sros_pkg::S_SETTLE;
                end
            end
            sros_pkg::S_SETTLE: begin
                n_disp[r_cur] = !(|r_block[r_cur]);
                n_fin_kind    = (|r_block[r_cur]) ? sros_pkg::KIND_QUEUED
                                                  : sros_pkg::KIND_DISPATCHED;
                n_fin_slot    = to_field(r_cur);
                n_state       = sros_pkg::S_FINAL;
            end
            sros_pkg::S_WAKE: begin
                if (!(|match) || out_free) begin
                    if (|match) begin
                        n_o_valid         = 1'b1;
                        n_o_kind          = sros_pkg::KIND_DISPATCHED;
                        n_o_slot          = to_field(match_idx);
                        n_o_last          = 1'b0;
                        n_disp[match_idx] = 1'b1;
                    end
                    if (r_cnt[SW-1:0] == SW'(SLOTS - 1)) begin
                        n_state = sros_pkg::S_FINAL;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            sros_pkg::S_FINAL: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = r_fin_kind;
                    n_o_slot  = r_fin_slot;
                    n_o_last  = 1'b1;
                    n_state   = sros_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sros_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sros_pkg::S_IDLE;
            r_valid    <= '0;
            r_disp     <= '0;
            r_nvalid   <= '0;
            r_rd_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_block[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_disp     <= n_disp;
            r_nvalid   <= n_nvalid;
            r_rd_valid <= issue;
            r_o_valid  <= n_o_valid;
            r_block    <= n_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd      <= i_s_axis_tuser;
            r_in_slot  <= i_s_axis_tdata[FW-1:0];
            r_in_start <= i_s_axis_tdata[FW +: SECTOR_BITS];
            r_in_count <= i_s_axis_tdata[FW + SECTOR_BITS +: CW];
        end
        r_rank     <= n_rank;
        r_mask     <= n_mask;
        r_cur      <= n_cur;
        r_cnt      <= n_cnt;
        r_fin_kind <= n_fin_kind;
        r_fin_slot <= n_fin_slot;
        r_rd_tag   <= r_cnt[SW-1:0];
        r_o_kind   <= n_o_kind;
        r_o_slot   <= n_o_slot;
        r_o_last   <= n_o_last;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = sros_pkg::OUT_TDATA_W'(r_o_slot);
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

endmodule

// ----- rtl/sros_checker.sv -----
// Port-level checker for the sector range order scheduler and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sros_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [sros_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [sros_pkg::KIND_W-1:0]      o_m_axis_tuser,
    input logic o_m_axis_tlast
);

    // A stalled result transaction must hold still.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "result changed while stalled")

    // The sequencer works on one request at a time.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken while busy")

    // Only wakeup dispatches come before the closing result.
    `ASSERT_SAME(a_nonlast_kind, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tuser == sros_pkg::KIND_DISPATCHED, "non-final result is not a dispatch")

    // A run of wakeups is always closed before new input is taken.
    `ASSERT_SAME(a_nonlast_busy, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready, "input ready inside a wakeup run")

endmodule

bind sector_range_order_scheduler_top sros_checker u_sros_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
